[rtl/core/bfbs_pkg.sv]
package bfbs_pkg;

  localparam int MAX_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int MAX_BITS  = MAX_BYTES * 8;
  localparam int CNT_W     = 16;
  localparam int HASH_W    = 32;
  localparam int ITER_W    = $clog2(HASH_W);
  localparam int ACT_W     = ADDR_W + 1;

  localparam logic [CNT_W-1:0] BIT_COUNT_RESET = CNT_W'(MAX_BITS);
  localparam logic [7:0]       BYTE_ZERO       = 8'h00;
  localparam logic [7:0]       BYTE_ONES       = 8'hff;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_CHECK  = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SETALL = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_FILL,
    ST_RESP
  } state_t;

  localparam logic KIND_MEMBER = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // Result of the shared modulo unit
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_res_t;

endpackage

[rtl/core/bloom_filter_bit_store_unit.sv]
// Bloom filter bit store.
// Requests arrive on in_valid/in_ready with operation, hash, last_hash and
// byte_index; answers leave on out_valid/out_ready as result_kind,
// possibly_present and byte_value. cfg_valid/cfg_ready/cfg_data write the
// bit count; cfg_ready is always high, so a write lands at once.
// One request is handled at a time and in_ready is low while it is at work.
// Add and check run through the bit-serial modulo in the shared divide unit,
// a step that takes its remainder, one read and one read-modify-write of the
// byte memory, and the idle state that takes the next request; a last check
// adds a step to load the output register. Read byte goes through a read, an
// update and the output register; clear all and set all write the active
// bytes, one memory write per cycle.
// After reset the block sweeps the 4096-byte store to zero, one byte per
// cycle, with in_ready low during the sweep; configuration writes are still
// taken. The answer sits in an output register: while the receiver stalls,
// requests that give no answer still go ahead, and one that has an answer
// waits until the register is free.
module bloom_filter_bit_store_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    operation,
  input  logic [bfbs_pkg::HASH_W-1:0]   hash,
  input  logic                          last_hash,
  input  logic [bfbs_pkg::ADDR_W-1:0]   byte_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic                          possibly_present,
  output logic [7:0]                    byte_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfbs_pkg::CNT_W-1:0]    cfg_data
);
  import bfbs_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   bit_count;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W:0]     n_plus;
  logic [ACT_W-1:0]   active;
  logic [ADDR_W-1:0]  top_byte;

  op_t                op;
  logic               last;
  logic [ADDR_W-1:0]  rd_index;
  logic [ADDR_W-1:0]  pos;
  logic [2:0]         bit_sel;
  logic [ADDR_W-1:0]  sweep;
  logic [7:0]         fill_byte;
  logic               check_miss;
  logic               miss_next;
  logic               res_kind;
  logic               res_pp;
  logic [7:0]         res_byte;

  logic               accept;
  logic               mod_start;
  mod_res_t           mod_res;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         bit_mask;

  // Effective count: zero counts as one, clamp to the store size
  always_comb begin
    if (bit_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (bit_count > CNT_W'(MAX_BITS)) begin
      n_eff = CNT_W'(MAX_BITS);
    end else begin
      n_eff = bit_count;
    end
  end

  assign n_plus   = {1'b0, n_eff} + (CNT_W + 1)'(7);
  assign active   = n_plus[ACT_W+2:3];
  assign top_byte = ADDR_W'((n_eff - CNT_W'(1)) >> 3);

  assign bit_mask  = 8'(1) << bit_sel;
  assign miss_next = check_miss | ((ram_rdata & bit_mask) == BYTE_ZERO);

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  bfbs_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .hash    (hash),
    .divisor (n_eff),
    .res     (mod_res)
  );

  bfbs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer: next state, handshake and memory controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mod_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = sweep;
    ram_wdata  = fill_byte;
    ram_re     = 1'b0;
    ram_raddr  = pos;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_ZERO;
        if (sweep == ADDR_W'(MAX_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(operation))
            OP_ADD, OP_CHECK: begin
              mod_start  = 1'b1;
              state_next = ST_MOD;
            end
            OP_CLEAR, OP_SETALL: state_next = ST_FILL;
            OP_READ:             state_next = ST_RD;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_res.done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
        if (op == OP_READ) begin
          ram_raddr = rd_index;
        end
        state_next = ST_UPD;
      end
      ST_UPD: begin
        case (op)
          OP_ADD: begin
            ram_we     = 1'b1;
            ram_waddr  = pos;
            ram_wdata  = ram_rdata | bit_mask;
            state_next = ST_IDLE;
          end
          OP_CHECK: state_next = last ? ST_RESP : ST_IDLE;
          OP_READ:  state_next = ST_RESP;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if ({1'b0, sweep} == active - ACT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        // Hold the answer until the output register is free
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count  <= BIT_COUNT_RESET;
      check_miss <= 1'b0;
      sweep      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bit_count <= cfg_data;
      end
      // Load a new answer when the register frees up, else drop a taken one
      if (state == ST_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: sweep <= sweep + 1'b1;
        ST_IDLE: sweep <= '0;
        ST_FILL: sweep <= sweep + 1'b1;
        ST_UPD: begin
          // Fold the bit into the sticky miss flag; drop it after the last hash
          if (op == OP_CHECK) begin
            check_miss <= last ? 1'b0 : miss_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= op_t'(operation);
      last      <= last_hash;
      rd_index  <= byte_index;
      fill_byte <= (op_t'(operation) == OP_SETALL) ? BYTE_ONES : BYTE_ZERO;
    end
    if (state == ST_MOD && mod_res.done) begin
      // Bytes are numbered from the top of the active range downwards
      pos     <= top_byte - mod_res.rem[ADDR_W+2:3];
      bit_sel <= mod_res.rem[2:0];
    end
    if (state == ST_UPD) begin
      if (op == OP_READ) begin
        res_kind <= KIND_BYTE;
        res_pp   <= 1'b0;
        res_byte <= ({1'b0, rd_index} < active) ? ram_rdata : BYTE_ZERO;
      end else begin
        res_kind <= KIND_MEMBER;
        res_pp   <= !miss_next;
        res_byte <= BYTE_ZERO;
      end
    end
    if (state == ST_RESP && (!out_valid || out_ready)) begin
      result_kind      <= res_kind;
      possibly_present <= res_pp;
      byte_value       <= res_byte;
    end
  end

  // The update step always follows a memory read
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> ($past(state) == ST_RD))
    else $error("update step without a preceding read");

  // A fill sweep never writes past the active bytes
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> ({1'b0, sweep} < active))
    else $error("fill sweep beyond active bytes");

  // A located byte lies inside the active range
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD && (op == OP_ADD || op == OP_CHECK)) |-> ({1'b0, pos} < active))
    else $error("hash located outside the active bytes");

  // The divide unit only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mod_res.done |-> (state == ST_MOD))
    else $error("modulo result arrived outside the modulo step");

  // No request is taken while an answer is pending
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> !in_ready)
    else $error("request accepted with an answer pending");

endmodule

[rtl/core/bfbs_ram.sv]
module bfbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bfbs_mod_unit.sv]
module bfbs_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bfbs_pkg::HASH_W-1:0]     hash,
  input  logic [bfbs_pkg::CNT_W-1:0]      divisor,
  output bfbs_pkg::mod_res_t              res
);
  import bfbs_pkg::*;

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [HASH_W-1:0] shreg;
  logic [CNT_W-1:0]  rem;
  logic              done;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // One restoring step: shift in the next hash bit, subtract when it fits
  assign trial = {rem, shreg[HASH_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        iter  <= '0;
        rem   <= '0;
        shreg <= hash;
      end else if (busy) begin
        shreg <= {shreg[HASH_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= diff[CNT_W-1:0];
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        iter <= iter + 1'b1;
        if (iter == ITER_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule
